// File: src/slip_frame_decoder_defines.svh
// assertion macros used by the slip frame decoder rtl
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define SFD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sfd_pkg.sv
// shared constants and types of the slip frame decoder
package sfd_pkg;

  localparam int unsigned PACKET_LIMIT = 4096;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned IDX_W        = 12;

  localparam logic [7:0] FRAME_END     = 8'hC0;
  localparam logic [7:0] FRAME_ESC     = 8'hDB;
  localparam logic [7:0] FRAME_ESC_END = 8'hDC;
  localparam logic [7:0] FRAME_ESC_ESC = 8'hDD;

  localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(PACKET_LIMIT);

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    status_t          status;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] data_index;
    logic [LEN_W-1:0] packet_length;
  } result_t;

endpackage

// File: src/sfd_decode.sv
// slip decode state, limit register and per-byte result logic
`include "slip_frame_decoder_defines.svh"

module sfd_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sfd_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                      take,
  input  logic [7:0]                in_byte,
  output sfd_pkg::result_t          res
);

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_ESCAPE   = 2'd1,
    MODE_CLEARING = 2'd2
  } mode_t;

  mode_t                     mode;
  mode_t                     mode_next;
  logic [sfd_pkg::LEN_W-1:0] byte_count;
  logic [sfd_pkg::LEN_W-1:0] byte_count_next;
  logic [sfd_pkg::LEN_W-1:0] max_packet_len;
  logic [sfd_pkg::LEN_W-1:0] limit;
  logic                      do_store;
  logic [7:0]                pay_byte;
  logic                      bad_esc_in;
  logic                      end_in;

  assign limit = (max_packet_len > sfd_pkg::LIMIT_MAX) ? sfd_pkg::LIMIT_MAX : max_packet_len;

  always_comb begin
    mode_next       = mode;
    byte_count_next = byte_count;
    do_store        = 1'b0;
    pay_byte        = in_byte;
    res             = '0;
    res.status      = sfd_pkg::ST_BUSY;
    unique case (mode)
      MODE_ESCAPE: begin
        if (in_byte == sfd_pkg::FRAME_ESC_END) begin
          mode_next = MODE_NORMAL;
          do_store  = 1'b1;
          pay_byte  = sfd_pkg::FRAME_END;
        end else if (in_byte == sfd_pkg::FRAME_ESC_ESC) begin
          mode_next = MODE_NORMAL;
          do_store  = 1'b1;
          pay_byte  = sfd_pkg::FRAME_ESC;
        end else begin
          mode_next  = MODE_CLEARING;
          res.status = sfd_pkg::ST_INVALID;
        end
      end
      MODE_CLEARING: begin
        // discard until end, which closes silently
        if (in_byte == sfd_pkg::FRAME_END) begin
          mode_next       = MODE_NORMAL;
          byte_count_next = '0;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (in_byte == sfd_pkg::FRAME_END) begin
          res.status        = sfd_pkg::ST_DONE;
          res.packet_length = byte_count;
          byte_count_next   = '0;
        end else if (in_byte == sfd_pkg::FRAME_ESC) begin
          mode_next = MODE_ESCAPE;
        end else begin
          do_store = 1'b1;
        end
      end
    endcase
    if (do_store) begin
      if (byte_count >= limit) begin
        res.status = sfd_pkg::ST_FULL;
      end else begin
        res.data_valid  = 1'b1;
        res.data_byte   = pay_byte;
        res.data_index  = byte_count[sfd_pkg::IDX_W-1:0];
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      byte_count     <= '0;
      max_packet_len <= sfd_pkg::LIMIT_MAX;
    end else begin
      if (cfg_we) begin
        max_packet_len <= cfg_wdata;
      end
      if (take) begin
        mode       <= mode_next;
        byte_count <= byte_count_next;
      end
    end
  end

  assign bad_esc_in = take && mode == MODE_ESCAPE &&
                      in_byte != sfd_pkg::FRAME_ESC_END && in_byte != sfd_pkg::FRAME_ESC_ESC;
  assign end_in     = take && mode != MODE_ESCAPE && in_byte == sfd_pkg::FRAME_END;

  `SFD_ASSERT_ALWAYS(a_count_cap, byte_count <= sfd_pkg::LIMIT_MAX, "byte count above packet limit")
  `SFD_ASSERT_NEXT(a_hold, !take, $stable(byte_count) && $stable(mode), "state moved without request")
  `SFD_ASSERT_NEXT(a_bad_esc, bad_esc_in, mode == MODE_CLEARING, "invalid escape not cleared")
  `SFD_ASSERT_NEXT(a_end_clr, end_in, byte_count == '0 && mode == MODE_NORMAL, "end not cleared")

endmodule

// File: src/sfd_out_reg.sv
// result register between decode logic and the output channel
module sfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfd_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output sfd_pkg::result_t res_out
);

  // room for a new request when empty or when the held one leaves now
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: src/slip_frame_decoder.sv
// slip frame decoder top level
// One received line byte per request, one result per byte. A byte is decoded in the cycle it is
// accepted and its result is held in an output register, so a new byte can be taken every cycle
// while the output side keeps pace; in_ready falls only while a finished result
// waits and out_ready is low. status: 0 in progress, 1 packet done (packet_length valid),
// 2 invalid escape (bytes then dropped up to the next END), 3 buffer full (payload byte dropped).
// data_valid marks a decoded payload byte with its data_index. The packet limit is cfg_wdata
// written with cfg_we, capped at 4096, reset 4096; write it only while the decoder is idle.
module slip_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [11:0] data_index,
  output logic [12:0] packet_length
);

  sfd_pkg::result_t res_comb;
  sfd_pkg::result_t res_reg;
  logic             take;

  assign take = in_valid && in_ready;

  sfd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .in_byte   (in_byte),
    .res       (res_comb)
  );

  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res_comb),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (in_ready),
    .res_out   (res_reg)
  );

  assign status        = res_reg.status;
  assign data_valid    = res_reg.data_valid;
  assign data_byte     = res_reg.data_byte;
  assign data_index    = res_reg.data_index;
  assign packet_length = res_reg.packet_length;

endmodule
